// ===== rtl/core/sat_syn_pkg.sv =====
// Shared constants, types and tables for the satellite channel synthesizer setup.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package sat_syn_pkg;

  localparam int unsigned ReqW       = 22;   // request width
  localparam int unsigned FreqW      = 19;   // request / 10, in 10 kHz units
  localparam int unsigned StepW      = 12;
  localparam int unsigned RecipW     = 16;
  localparam int unsigned IdxW       = 7;    // index within a band, up to 81
  localparam int unsigned RemW       = 12;   // remainder, below 4000
  localparam int unsigned ChanW      = 10;   // channel ID or resolved channel
  localparam int unsigned LoW        = 22;
  localparam int unsigned SdW        = 22;

  // Divide by ten: exact for every 22-bit value with a 25-bit shift.
  localparam int unsigned            Div10Shift = 25;
  localparam logic [ReqW-1:0]        Div10Recip = 22'd3355444;

  // Band division: floor reciprocal, off by at most one, fixed up after.
  localparam int unsigned            RecipShift = 27;

  localparam logic [FreqW-1:0]       Band0Base  = 19'd104948;
  localparam logic [FreqW-1:0]       Band1Base  = 19'd161300;
  localparam logic [FreqW-1:0]       Band2Base  = 19'd159300;
  localparam logic [StepW-1:0]       Band0Step  = 12'd3836;
  localparam logic [StepW-1:0]       Band12Step = 12'd4000;
  localparam logic [RecipW-1:0]      Band0Recip = 16'd34988;
  localparam logic [RecipW-1:0]      Band12Recip = 16'd33554;

  localparam logic [ChanW-1:0]       ChanMax    = 10'd35;
  localparam logic [5:0]             ChanPerBand = 6'd12;
  localparam logic [IdxW-1:0]        Band1ChanOfs = 7'd12;
  localparam logic [IdxW-1:0]        Band2ChanOfs = 7'd24;

  // Oscillator frequency: base and step times ten, plus or minus the side offset.
  localparam logic [LoW-1:0]         Band0Lo     = 22'd1049480;
  localparam logic [LoW-1:0]         Band1Lo     = 22'd1613000;
  localparam logic [LoW-1:0]         Band2Lo     = 22'd1593000;
  localparam logic [15:0]            Band0LoStep = 16'd38360;
  localparam logic [15:0]            Band12LoStep = 16'd40000;
  localparam logic [LoW-1:0]         LoOffset    = 22'd500;

  // The upper side word is the lower side word plus this, modulo 2^22.
  localparam logic [SdW-1:0]         SdSideOffset = 22'h010000;

  localparam int unsigned            VcoRanges = 8;
  localparam logic [LoW-1:0] VcoEdge [VcoRanges+1] = '{
    22'd2151000, 22'd1950000, 22'd1800000, 22'd1600000, 22'd1450000,
    22'd1250000, 22'd1200000, 22'd975000,  22'd950000
  };
  localparam logic VcoDiv [VcoRanges] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam logic [2:0] VcoCode [VcoRanges] = '{
    3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6
  };

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadChan = 2'd1,
    StatusNoSynth = 2'd2,
    StatusBelow   = 2'd3
  } status_e;

  typedef struct packed {
    logic [SdW-1:0] sd;
    logic [4:0]     n;
    logic [3:0]     a;
  } synth_t;

  // Resolved request handed from band selection to the tuning stages.
  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic             below;
  } chan_req_t;

  // Lower side synth words for channels 0 to 23.
  function automatic synth_t synth_lookup(input logic [4:0] ch);
    synth_t s;
    unique case (ch)
      5'd0:    s = '{sd: 22'h38fae1, n: 5'h0d, a: 4'h5};
      5'd1:    s = '{sd: 22'h3f570a, n: 5'h0e, a: 4'h3};
      5'd2:    s = '{sd: 22'h05b333, n: 5'h0e, a: 4'h5};
      5'd3:    s = '{sd: 22'h3c0f5c, n: 5'h0f, a: 4'h4};
      5'd4:    s = '{sd: 22'h026b85, n: 5'h0f, a: 4'h6};
      5'd5:    s = '{sd: 22'h38c7ae, n: 5'h10, a: 4'h5};
      5'd6:    s = '{sd: 22'h3f23d7, n: 5'h11, a: 4'h3};
      5'd7:    s = '{sd: 22'h058000, n: 5'h11, a: 4'h5};
      5'd8:    s = '{sd: 22'h3bdc28, n: 5'h12, a: 4'h4};
      5'd9:    s = '{sd: 22'h023851, n: 5'h12, a: 4'h6};
      5'd10:   s = '{sd: 22'h38947a, n: 5'h13, a: 4'h5};
      5'd11:   s = '{sd: 22'h3ef0a3, n: 5'h14, a: 4'h3};
      5'd12:   s = '{sd: 22'h3c8000, n: 5'h16, a: 4'h4};
      5'd13:   s = '{sd: 22'h048000, n: 5'h16, a: 4'h6};
      5'd14:   s = '{sd: 22'h3c8000, n: 5'h17, a: 4'h5};
      5'd15:   s = '{sd: 22'h048000, n: 5'h18, a: 4'h3};
      5'd16:   s = '{sd: 22'h3c8000, n: 5'h18, a: 4'h6};
      5'd17:   s = '{sd: 22'h048000, n: 5'h19, a: 4'h4};
      5'd18:   s = '{sd: 22'h3c8000, n: 5'h1a, a: 4'h3};
      5'd19:   s = '{sd: 22'h048000, n: 5'h1a, a: 4'h5};
      5'd20:   s = '{sd: 22'h3c8000, n: 5'h1b, a: 4'h4};
      5'd21:   s = '{sd: 22'h048000, n: 5'h1b, a: 4'h6};
      5'd22:   s = '{sd: 22'h3c8000, n: 5'h1c, a: 4'h5};
      5'd23:   s = '{sd: 22'h048000, n: 5'h1d, a: 4'h3};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sat_syn_fit.sv =====
// Two-stage band fit: index and remainder of (freq - base) / step for one band.
// Depends on sat_syn_pkg for widths and the reciprocal shift.
`default_nettype none

module sat_syn_fit (
  input  logic                             clk_i,
  input  logic [sat_syn_pkg::FreqW-1:0]    freq_i,
  input  logic [sat_syn_pkg::FreqW-1:0]    base_i,
  input  logic [sat_syn_pkg::StepW-1:0]    step_i,
  input  logic [sat_syn_pkg::RecipW-1:0]   recip_i,
  output logic                             ok_o,
  output logic [sat_syn_pkg::IdxW-1:0]     idx_o,
  output logic [sat_syn_pkg::RemW-1:0]     rem_o
);

  localparam int unsigned ProdW = sat_syn_pkg::FreqW + sat_syn_pkg::RecipW;

  logic                            ok_d, ok_q;
  logic [sat_syn_pkg::FreqW-1:0]   diff_d, diff_q;
  logic [sat_syn_pkg::IdxW-1:0]    quo_d, quo_q;
  logic [ProdW-1:0]                prod;

  logic [sat_syn_pkg::FreqW-1:0]   part;
  logic [sat_syn_pkg::FreqW-1:0]   rem_raw;
  logic                            ok2_d, ok2_q;
  logic [sat_syn_pkg::IdxW-1:0]    idx_d, idx_q;
  logic [sat_syn_pkg::RemW-1:0]    rem_d, rem_q;

  // Stage one: offset from the band base and a quotient estimate.
  always_comb begin
    ok_d   = (freq_i >= base_i);
    diff_d = freq_i - base_i;
    prod   = ProdW'(diff_d) * ProdW'(recip_i);
    quo_d  = prod[sat_syn_pkg::RecipShift +: sat_syn_pkg::IdxW];
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    diff_q <= diff_d;
    quo_q  <= quo_d;
  end

  // Stage two: the estimate can be one short; fix it up with one compare.
  always_comb begin
    part    = sat_syn_pkg::FreqW'(quo_q) * sat_syn_pkg::FreqW'(step_i);
    rem_raw = diff_q - part;
    ok2_d   = ok_q;
    if (rem_raw >= sat_syn_pkg::FreqW'(step_i)) begin
      idx_d = quo_q + sat_syn_pkg::IdxW'(1);
      rem_d = sat_syn_pkg::RemW'(rem_raw - sat_syn_pkg::FreqW'(step_i));
    end else begin
      idx_d = quo_q;
      rem_d = sat_syn_pkg::RemW'(rem_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    ok2_q <= ok2_d;
    idx_q <= idx_d;
    rem_q <= rem_d;
  end

  assign ok_o  = ok2_q;
  assign idx_o = idx_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/sat_syn_tune.sv =====
// Tuning stages: channel to transponder, oscillator frequency, synth words,
// then VCO range match into the output registers. Depends on sat_syn_pkg.
`default_nettype none

module sat_syn_tune (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  sat_syn_pkg::chan_req_t        req_i,
  input  logic                          lo_side_i,
  output logic                          done_o,
  output logic [5:0]                    channel_o,
  output logic [4:0]                    transponder_number_o,
  output logic [sat_syn_pkg::LoW-1:0]   lo_freq_khz_o,
  output logic                          band_found_o,
  output logic                          div_select_o,
  output logic [2:0]                    vco_band_o,
  output logic [sat_syn_pkg::SdW-1:0]   sd_word_o,
  output logic [4:0]                    n_value_o,
  output logic [3:0]                    a_value_o,
  output logic [1:0]                    status_o
);

  // First channel of band 2.
  localparam logic [5:0] Band2Chan = 6'(2 * sat_syn_pkg::ChanPerBand);

  // ---------------- stage five: channel decode ----------------
  logic                            over;
  logic                            drop;
  logic [5:0]                      ch6;
  logic [3:0]                      k;
  logic [4:0]                      num;
  logic [sat_syn_pkg::LoW-1:0]     lo_base;
  logic [sat_syn_pkg::LoW-1:0]     lo;
  sat_syn_pkg::synth_t             syn;
  sat_syn_pkg::status_e            status_d;

  logic                            v5_q;
  logic [5:0]                      ch_q;
  logic [4:0]                      num_q;
  logic [sat_syn_pkg::LoW-1:0]     lo_q;
  sat_syn_pkg::synth_t             syn_q;
  sat_syn_pkg::status_e            status_q;

  always_comb begin
    over    = !req_i.below && (req_i.chan > sat_syn_pkg::ChanMax);
    drop    = req_i.below || over;
    ch6     = req_i.chan[5:0];
    syn     = '0;
    if (ch6 < sat_syn_pkg::ChanPerBand) begin
      k       = ch6[3:0];
      num     = {k, 1'b1};
      lo_base = sat_syn_pkg::Band0Lo
              + sat_syn_pkg::LoW'(20'(sat_syn_pkg::Band0LoStep) * 20'(k));
    end else if (ch6 < Band2Chan) begin
      k       = 4'(ch6 - sat_syn_pkg::ChanPerBand);
      num     = {k + 4'd1, 1'b0};
      lo_base = sat_syn_pkg::Band1Lo
              + sat_syn_pkg::LoW'(20'(sat_syn_pkg::Band12LoStep) * 20'(k));
    end else begin
      k       = 4'(ch6 - Band2Chan);
      num     = {k, 1'b1};
      lo_base = sat_syn_pkg::Band2Lo
              + sat_syn_pkg::LoW'(20'(sat_syn_pkg::Band12LoStep) * 20'(k));
    end
    lo = lo_side_i ? lo_base + sat_syn_pkg::LoOffset : lo_base - sat_syn_pkg::LoOffset;

    if (ch6 < Band2Chan) begin
      syn = sat_syn_pkg::synth_lookup(ch6[4:0]);
      if (lo_side_i) begin
        syn.sd = syn.sd + sat_syn_pkg::SdSideOffset;
      end
    end

    if (req_i.below) begin
      status_d = sat_syn_pkg::StatusBelow;
    end else if (over) begin
      status_d = sat_syn_pkg::StatusBadChan;
    end else if (ch6 >= Band2Chan) begin
      status_d = sat_syn_pkg::StatusNoSynth;
    end else begin
      status_d = sat_syn_pkg::StatusOk;
    end

    // Failed requests report status only.
    if (drop) begin
      ch6 = '0;
      num = '0;
      lo  = '0;
      syn = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch6;
    num_q    <= num;
    lo_q     <= lo;
    syn_q    <= syn;
    status_q <= status_d;
  end

  // ---------------- stage six: VCO range match ----------------
  logic        found;
  logic        div_sel;
  logic [2:0]  code;
  logic        v6_q;

  always_comb begin
    found   = 1'b0;
    div_sel = 1'b0;
    code    = '0;
    for (int i = 0; i < sat_syn_pkg::VcoRanges; i++) begin
      if (lo_q >= sat_syn_pkg::VcoEdge[i+1] && lo_q < sat_syn_pkg::VcoEdge[i]) begin
        found   = 1'b1;
        div_sel = sat_syn_pkg::VcoDiv[i];
        code    = sat_syn_pkg::VcoCode[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    channel_o            <= ch_q;
    transponder_number_o <= num_q;
    lo_freq_khz_o        <= lo_q;
    band_found_o         <= found;
    div_select_o         <= div_sel;
    vco_band_o           <= code;
    sd_word_o            <= syn_q.sd;
    n_value_o            <= syn_q.n;
    a_value_o            <= syn_q.a;
    status_o             <= status_q;
  end

  assign done_o = v6_q;

endmodule

`default_nettype wire

// ===== rtl/core/satellite_channel_synth_setup.sv =====
// Top level of the satellite channel synthesizer setup pipeline.
// Depends on sat_syn_pkg, sat_syn_fit and sat_syn_tune.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+--------------------------------
//   request   | in        | start, busy          | request_khz_i
//   result    | out       | done_o (one cycle)   | channel_o ... status_o
//   config    | in        | cfg_we_i             | cfg_wdata_i (lo_side)
//
// Six register stages: divide by ten, two band-fit stages, band select,
// channel decode, VCO match. A new request is taken every cycle while busy
// is low; its result strobes on done_o from the VCO match registers.
// busy is high only during reset and the first cycle after it.
// There is no stall: results must be taken in the cycle they appear.
`default_nettype none

module satellite_channel_synth_setup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sat_syn_pkg::ReqW-1:0]  request_khz_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          done_o,
  output logic [5:0]                    channel_o,
  output logic [4:0]                    transponder_number_o,
  output logic [sat_syn_pkg::LoW-1:0]   lo_freq_khz_o,
  output logic                          band_found_o,
  output logic                          div_select_o,
  output logic [2:0]                    vco_band_o,
  output logic [sat_syn_pkg::SdW-1:0]   sd_word_o,
  output logic [4:0]                    n_value_o,
  output logic [3:0]                    a_value_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned Div10W = 2 * sat_syn_pkg::ReqW;
  localparam int unsigned IdW    = 10;

  logic busy_q;
  logic lo_side_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      lo_side_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        lo_side_q <= cfg_wdata_i;
      end
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // ---------------- stage one: divide by ten ----------------
  logic [Div10W-1:0]               prod10;
  logic [sat_syn_pkg::FreqW-1:0]   f1_q;
  logic                            id1_q, id2_q, id3_q;
  logic [IdW-1:0]                  idv1_q, idv2_q, idv3_q;
  logic                            v1_q, v2_q, v3_q, v4_q;

  assign prod10 = Div10W'(request_khz_i) * Div10W'(sat_syn_pkg::Div10Recip);

  always_ff @(posedge clk_i) begin
    f1_q   <= prod10[sat_syn_pkg::Div10Shift +: sat_syn_pkg::FreqW];
    id1_q  <= (request_khz_i[sat_syn_pkg::ReqW-1:IdW] == '0);
    idv1_q <= request_khz_i[IdW-1:0];
    id2_q  <= id1_q;
    idv2_q <= idv1_q;
    id3_q  <= id2_q;
    idv3_q <= idv2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------- stages two and three: band fits ----------------
  logic                            ok0, ok1, ok2;
  logic [sat_syn_pkg::IdxW-1:0]    idx0, idx1, idx2;
  logic [sat_syn_pkg::RemW-1:0]    rem0, rem1, rem2;

  sat_syn_fit u_fit0 (
    .clk_i   (clk_i),
    .freq_i  (f1_q),
    .base_i  (sat_syn_pkg::Band0Base),
    .step_i  (sat_syn_pkg::Band0Step),
    .recip_i (sat_syn_pkg::Band0Recip),
    .ok_o    (ok0),
    .idx_o   (idx0),
    .rem_o   (rem0)
  );

  sat_syn_fit u_fit1 (
    .clk_i   (clk_i),
    .freq_i  (f1_q),
    .base_i  (sat_syn_pkg::Band1Base),
    .step_i  (sat_syn_pkg::Band12Step),
    .recip_i (sat_syn_pkg::Band12Recip),
    .ok_o    (ok1),
    .idx_o   (idx1),
    .rem_o   (rem1)
  );

  sat_syn_fit u_fit2 (
    .clk_i   (clk_i),
    .freq_i  (f1_q),
    .base_i  (sat_syn_pkg::Band2Base),
    .step_i  (sat_syn_pkg::Band12Step),
    .recip_i (sat_syn_pkg::Band12Recip),
    .ok_o    (ok2),
    .idx_o   (idx2),
    .rem_o   (rem2)
  );

  // ---------------- stage four: band select ----------------
  logic                            have;
  logic [sat_syn_pkg::IdxW-1:0]    best_ch;
  logic [sat_syn_pkg::RemW-1:0]    best_rem;
  sat_syn_pkg::chan_req_t          sel_d, sel_q;

  // Band 1 first so that it wins ties; strict compares keep band 0 ahead of band 2.
  always_comb begin
    have     = ok1;
    best_ch  = idx1 + sat_syn_pkg::Band1ChanOfs;
    best_rem = rem1;
    if (ok0 && (!have || rem0 < best_rem)) begin
      have     = 1'b1;
      best_ch  = idx0;
      best_rem = rem0;
    end
    if (ok2 && (!have || rem2 < best_rem)) begin
      have     = 1'b1;
      best_ch  = idx2 + sat_syn_pkg::Band2ChanOfs;
      best_rem = rem2;
    end
    if (id3_q) begin
      sel_d.chan  = idv3_q;
      sel_d.below = 1'b0;
    end else begin
      sel_d.chan  = sat_syn_pkg::ChanW'(best_ch);
      sel_d.below = !have;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
  end

  // ---------------- stages five and six ----------------
  sat_syn_tune u_tune (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (v4_q),
    .req_i                (sel_q),
    .lo_side_i            (lo_side_q),
    .done_o               (done_o),
    .channel_o            (channel_o),
    .transponder_number_o (transponder_number_o),
    .lo_freq_khz_o        (lo_freq_khz_o),
    .band_found_o         (band_found_o),
    .div_select_o         (div_select_o),
    .vco_band_o           (vco_band_o),
    .sd_word_o            (sd_word_o),
    .n_value_o            (n_value_o),
    .a_value_o            (a_value_o),
    .status_o             (status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sat_syn_check.sv =====
// Port-level checks for satellite_channel_synth_setup, attached with bind.
// Depends on sat_syn_pkg for widths and status codes.
`default_nettype none

module sat_syn_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [5:0]                    channel_o,
  input logic [4:0]                    transponder_number_o,
  input logic [sat_syn_pkg::LoW-1:0]   lo_freq_khz_o,
  input logic                          band_found_o,
  input logic                          div_select_o,
  input logic [2:0]                    vco_band_o,
  input logic [sat_syn_pkg::SdW-1:0]   sd_word_o,
  input logic [4:0]                    n_value_o,
  input logic [3:0]                    a_value_o,
  input logic [1:0]                    status_o
);

  // A result only ever follows an earlier request taken with busy low.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("result without a request six cycles earlier");

  // Requests that fail report status and nothing else.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == sat_syn_pkg::StatusBelow ||
                status_o == sat_syn_pkg::StatusBadChan)) |->
    (channel_o == '0 && transponder_number_o == '0 && lo_freq_khz_o == '0 &&
     band_found_o == 1'b0 && sd_word_o == '0 && n_value_o == '0 && a_value_o == '0))
    else $error("failed request carries nonzero fields");

  // Missing synth entries only for band 2 channels, with the synth words cleared.
  a_no_synth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == sat_syn_pkg::StatusNoSynth) |->
    (channel_o >= 6'd24 && channel_o <= 6'd35 &&
     sd_word_o == '0 && n_value_o == '0 && a_value_o == '0))
    else $error("no-synth status on wrong channel or with synth words");

  a_ok_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == sat_syn_pkg::StatusOk) |->
    (channel_o < 6'd24 && transponder_number_o != '0))
    else $error("ok status outside bands 0 and 1");

  a_vco_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !band_found_o) |-> (!div_select_o && vco_band_o == '0))
    else $error("VCO fields set without a matching range");

endmodule

bind satellite_channel_synth_setup sat_syn_check u_sat_syn_check (.*);

`default_nettype wire
